// File: rtl/core/unsigned_divide_32_by_16_with_flags_assert.svh
// Assertion macros for the divider. Each expects clk and rst_n in scope.
`ifndef UNSIGNED_DIVIDE_32_BY_16_WITH_FLAGS_ASSERT_SVH
`define UNSIGNED_DIVIDE_32_BY_16_WITH_FLAGS_ASSERT_SVH

// Same-cycle implication.
`define UDIV_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define UDIV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/udiv_pkg.sv
package udiv_pkg;

    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 16;
    localparam int QUO_W      = 16;
    localparam int NUM_CELLS  = QUO_W;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_DIVZERO  = 2'd2
    } udiv_status_t;

    typedef struct packed {
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } udiv_in_t;

    typedef struct packed {
        logic [DIVIDEND_W-1:0] result_word;
        logic                  write_dest;
        logic                  flags_update;
        logic                  flag_n;
        logic                  flag_z;
        logic                  flag_v;
        logic                  flag_c;
        udiv_status_t          status;
    } udiv_out_t;

    // State carried from one cell of the array to the next.
    typedef struct packed {
        logic                 valid;
        logic                 div_zero;
        logic                 overflow;
        logic [QUO_W-1:0]     rem;
        logic [QUO_W-1:0]     low;
        logic [DIVISOR_W-1:0] divisor;
    } udiv_stage_t;

endpackage

// File: rtl/core/udiv_cell.sv
module udiv_cell
    import udiv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  udiv_stage_t stage_in,
    output udiv_stage_t stage_out
);

    udiv_stage_t      stage_reg;
    udiv_stage_t      stage_next;
    logic [QUO_W:0]   partial;
    logic [QUO_W:0]   diff;
    logic             ge;

    // One restoring step: bring down the next dividend bit and try to subtract.
    always_comb
    begin
        partial    = {stage_in.rem, stage_in.low[QUO_W-1]};
        ge         = partial >= {1'b0, stage_in.divisor};
        diff       = partial - {1'b0, stage_in.divisor};
        stage_next = stage_in;
        stage_next.rem = ge ? diff[QUO_W-1:0] : partial[QUO_W-1:0];
        stage_next.low = {stage_in.low[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

// File: rtl/core/udiv_flags.sv
module udiv_flags
    import udiv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  udiv_stage_t stage_in,
    output logic        done,
    output udiv_out_t   result
);

    logic      done_reg;
    udiv_out_t result_reg;
    udiv_out_t result_next;

    always_comb
    begin
        result_next        = '0;
        result_next.status = ST_DONE;
        if (stage_in.div_zero)
        begin
            result_next.status = ST_DIVZERO;
        end
        else if (stage_in.overflow)
        begin
            result_next.flags_update = 1'b1;
            result_next.flag_v       = 1'b1;
            result_next.status       = ST_OVERFLOW;
        end
        else
        begin
            result_next.result_word  = {stage_in.rem, stage_in.low};
            result_next.write_dest   = 1'b1;
            result_next.flags_update = 1'b1;
            result_next.flag_n       = stage_in.low[QUO_W-1];
            result_next.flag_z       = stage_in.low == '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: rtl/core/unsigned_divide_32_by_16_with_flags.sv
// Unsigned 32-by-16 divide with condition flags.
// A request is taken at a rising clock edge where start is high and busy is low;
// the operands port then carries the 32-bit dividend and the 16-bit divisor.
// Each request yields exactly one result on the result port, marked by done for
// a single cycle. The result cannot be held off, so a consumer must take it then.
// The divider is a linear array of sixteen restoring cells, one per quotient
// bit, each followed by a register. A request passes through the operand
// register, the sixteen cell registers and the output register in turn.
// A new request may enter on every cycle, so throughput is one request per
// clock; the rate is set by the single compare-and-subtract in each cell.
// Quotient overflow and a zero divisor are detected in the operand stage and
// ride down the array with the request; the final stage formats the flags.
// Reset clears every valid bit in the array, so no stale result appears, and
// holds busy high until the first clock edge after reset is released.
module unsigned_divide_32_by_16_with_flags
    import udiv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  udiv_in_t  operands,
    output logic      done,
    output udiv_out_t result
);

`include "unsigned_divide_32_by_16_with_flags_assert.svh"

    logic        busy_reg;
    logic        busy_next;
    logic        accept;
    udiv_stage_t stage0_reg;
    udiv_stage_t stage0_next;
    udiv_stage_t chain [0:NUM_CELLS];

    assign accept    = start && !busy_reg;
    assign busy_next = 1'b0;

    // The quotient fits in sixteen bits exactly when the high half of the
    // dividend is below the divisor, which also keeps every partial remainder
    // in sixteen bits as it moves down the array.
    always_comb
    begin
        stage0_next          = '0;
        stage0_next.valid    = accept;
        stage0_next.divisor  = operands.divisor;
        stage0_next.rem      = operands.dividend[DIVIDEND_W-1:QUO_W];
        stage0_next.low      = operands.dividend[QUO_W-1:0];
        stage0_next.div_zero = operands.divisor == '0;
        stage0_next.overflow = (operands.divisor != '0) &&
            (operands.dividend[DIVIDEND_W-1:QUO_W] >= operands.divisor);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b1;
            stage0_reg <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            stage0_reg <= stage0_next;
        end
    end

    assign chain[0] = stage0_reg;

    // Each cell produces one quotient bit, most significant first.
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        udiv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    udiv_flags u_flags (
        .clk      (clk),
        .rst_n    (rst_n),
        .stage_in (chain[NUM_CELLS]),
        .done     (done),
        .result   (result)
    );

    assign busy = busy_reg;

    // A request leaving the last cell is reported on the next cycle.
    `UDIV_ASSERT_NEXT(a_done_follows, chain[NUM_CELLS].valid, done, "result strobe missing")
    // No result appears without a request leaving the array.
    `UDIV_ASSERT_IMPLY(a_done_source, done, $past(chain[NUM_CELLS].valid), "spurious result")
    // A register write only ever accompanies a successful divide.
    `UDIV_ASSERT_IMPLY(a_write_ok, done && result.write_dest, result.status == ST_DONE && result.flags_update, "write without success")
    // A zero divisor must leave the flags untouched.
    `UDIV_ASSERT_NEXT(a_divzero, chain[NUM_CELLS].valid && chain[NUM_CELLS].div_zero, result.status == ST_DIVZERO && !result.flags_update && !result.write_dest, "divide by zero mishandled")

endmodule

// File: verif/unsigned_divide_32_by_16_with_flags_tb.sv
`timescale 1ns / 100ps

// Testbench for the unsigned 32-by-16 divider with condition flags.
//
// Requests are driven at the rising clock edge and counted as accepted at the
// first edge where start is high and busy is low. Each accepted request gets
// its expected result from a local divide model. That result is queued. Every
// cycle in which done is high, the result is taken and checked field by field
// against the oldest queued result. The divider cannot hold its results back,
// so only the request side idles.
module unsigned_divide_32_by_16_with_flags_tb;
    import udiv_pkg::*;

    // The quotient must not exceed this value for the destination to be written.
    localparam logic [31:0] QUOTIENT_LIMIT = 32'h0000_ffff;
    localparam int          HALF_WIDTH     = 16;

    // After the last expected result, the bench waits out this drain margin so
    // that a stray late result is still caught.
    localparam int DRAIN_CYCLES = 24;
    localparam int DRAIN_LIMIT  = 2000;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    udiv_in_t  operands;
    logic      done;
    udiv_out_t result;

    // Results still owed by the divider, oldest first.
    udiv_out_t pending_divides[$];
    int        mismatches;
    bit        pauses_enabled;

    unsigned_divide_32_by_16_with_flags dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operands (operands),
        .done     (done),
        .result   (result)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // This is the divide as the block must perform it. A zero divisor touches
    // nothing and only reports an error. A quotient that needs more than 16 bits
    // updates the flags with V set but writes no destination. Otherwise the
    // remainder and the quotient are packed into one word, N is taken from
    // quotient bit 15 and Z is set for a zero quotient.
    function automatic udiv_out_t divu_result(udiv_in_t req);
        udiv_out_t   res;
        logic [31:0] quo;
        logic [31:0] rem;
        res        = '0;
        res.status = ST_DONE;
        if (req.divisor == '0)
        begin
            res.status = ST_DIVZERO;
            return res;
        end
        quo              = req.dividend / {16'd0, req.divisor};
        rem              = req.dividend % {16'd0, req.divisor};
        res.flags_update = 1'b1;
        if (quo > QUOTIENT_LIMIT)
        begin
            res.flag_v = 1'b1;
            res.status = ST_OVERFLOW;
            return res;
        end
        res.result_word = {rem[HALF_WIDTH-1:0], quo[HALF_WIDTH-1:0]};
        res.write_dest  = 1'b1;
        res.flag_n      = quo[HALF_WIDTH-1];
        res.flag_z      = (quo == '0);
        return res;
    endfunction

    // Drops start for a number of cycles. Garbage goes on the operand bus
    // during the pause, because the divider must ignore it while start is low.
    task automatic pause_requests(input int cycles);
        start    <= 1'b0;
        operands <= {$urandom, 16'($urandom_range(0, 16'hffff))};
        repeat (cycles) @(posedge clk);
    endtask

    // Presents one request and holds it until it is taken. Busy is a registered
    // output, so its value at the falling edge is the value that the next rising
    // edge sees. Unless a pause is drawn, the caller returns at the accepting edge
    // and start stays high, so the next request can follow directly. Each idle
    // cycle is drawn on its own, with a chance of 37 percent.
    task automatic send_request(input logic [31:0] num, input logic [15:0] den);
        udiv_in_t req;
        logic     was_busy;
        req.dividend = num;
        req.divisor  = den;
        start    <= 1'b1;
        operands <= req;
        do
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
        end
        while (was_busy);
        pending_divides.push_back(divu_result(req));
        if (pauses_enabled)
        begin
            while ($urandom_range(0, 99) < 37)
            begin
                pause_requests(1);
            end
        end
    endtask

    // Draws one operand pair. Most requests are built as quotient * divisor +
    // remainder with a remainder below the divisor, so they fit and reach the
    // write path. Others sit right at the 16-bit quotient boundary, are fully
    // random (about half of these overflow), or carry a zero divisor. The width of the
    // divisor is drawn too, so small divisors show up often.
    task automatic random_operands(output logic [31:0] num, output logic [15:0] den);
        int          kind;
        int          width;
        logic [15:0] quo;
        logic [15:0] rem;
        longint      product;
        kind  = $urandom_range(0, 99);
        width = $urandom_range(1, HALF_WIDTH);
        den   = 16'($urandom_range(0, 16'hffff) & (16'hffff >> (HALF_WIDTH - width)));
        if (den == '0)
        begin
            den = 16'd1;
        end
        if (kind < 55)
        begin
            case ($urandom_range(0, 7))
                0:       quo = 16'hffff;
                1:       quo = 16'h0000;
                2:       quo = 16'(16'h8000 | $urandom_range(0, 3));
                default: quo = 16'($urandom_range(0, 16'hffff));
            endcase
            rem = 16'($urandom_range(0, den - 1));
            num = 32'(quo) * 32'(den) + 32'(rem);
        end
        else if (kind < 75)
        begin
            // Quotient of 0xffff, 0x10000 or 0x10001, saturated at the top of
            // the dividend range when the product will not fit.
            product = (longint'(16'hffff) + $urandom_range(0, 2)) * den
                      + $urandom_range(0, den - 1);
            num = (product > 64'h0000_0000_ffff_ffff) ? 32'hffff_ffff : product[31:0];
        end
        else if (kind < 95)
        begin
            num = $urandom;
            den = 16'($urandom_range(0, 16'hffff));
        end
        else
        begin
            num = $urandom;
            den = '0;
        end
    endtask

    // Corner cases. The first request goes out right after reset, so it also
    // waits out the busy period at release.
    task automatic test_corner_cases();
        send_request(32'h0000_0000, 16'h0001);   // zero quotient, zero remainder
        send_request(32'h0000_0005, 16'h0007);   // zero quotient, remainder kept
        send_request(32'h0000_0000, 16'hffff);
        send_request(32'h0000_ffff, 16'h0001);   // largest quotient, N set
        send_request(32'h0000_7fff, 16'h0001);   // N clear just below bit 15
        send_request(32'h0000_8000, 16'h0001);   // N set at bit 15
        send_request(32'h0001_0000, 16'h0001);   // first quotient that overflows
        send_request(32'hffff_ffff, 16'h0001);
        send_request(32'hffff_ffff, 16'hffff);   // overflows, quotient 0x10001
        send_request(32'hfffe_ffff, 16'hffff);   // quotient 0xffff, largest remainder
        send_request(32'h7fff_ffff, 16'h8000);   // quotient 0xffff, remainder 0x7fff
        send_request(32'h8000_0000, 16'h8000);   // quotient 0x10000
        send_request(32'h0000_0000, 16'h0000);   // divide by zero
        send_request(32'hffff_ffff, 16'h0000);
        send_request(32'h1234_5678, 16'h0000);
        send_request(32'haaaa_aaaa, 16'haaab);
        send_request(32'h5555_5555, 16'h5556);
        send_request(32'h0000_fffe, 16'hffff);
    endtask

    // Random traffic with pauses on the request side.
    task automatic test_random_traffic(input int count);
        logic [31:0] num;
        logic [15:0] den;
        pauses_enabled = 1'b1;
        repeat (count)
        begin
            random_operands(num, den);
            send_request(num, den);
        end
    endtask

    // Back-to-back requests with no gap at all. This fills the whole array
    // and gives one result per cycle.
    task automatic test_streaming(input int count);
        logic [31:0] num;
        logic [15:0] den;
        pauses_enabled = 1'b0;
        repeat (count)
        begin
            random_operands(num, den);
            send_request(num, den);
        end
    endtask

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
            mismatches++;
        end
    endtask

    // The result is sampled at the edge that ends its strobe cycle. The block's
    // outputs change only after this edge, so the values read here are the
    // values that were present during the cycle.
    always @(posedge clk)
    begin
        udiv_out_t want;
        if (rst_n && done)
        begin
            if (pending_divides.size() == 0)
            begin
                $display("%0t: result with no request outstanding: expected none, actual %h",
                         $time, result);
                mismatches++;
            end
            else
            begin
                want = pending_divides.pop_front();
                check_field("result_word",  want.result_word,  result.result_word);
                check_field("write_dest",   32'(want.write_dest),   32'(result.write_dest));
                check_field("flags_update", 32'(want.flags_update), 32'(result.flags_update));
                check_field("flag_n",       32'(want.flag_n),       32'(result.flag_n));
                check_field("flag_z",       32'(want.flag_z),       32'(result.flag_z));
                check_field("flag_v",       32'(want.flag_v),       32'(result.flag_v));
                check_field("flag_c",       32'(want.flag_c),       32'(result.flag_c));
                check_field("status",       32'(want.status),       32'(result.status));
            end
        end
    end

    initial
    begin
        int waited;
        mismatches     = 0;
        pauses_enabled = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        operands       = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_corner_cases();
        test_random_traffic(400);
        test_streaming(150);
        test_random_traffic(150);
        start <= 1'b0;

        // Let the array drain, then wait out the drain margin so that any
        // result that should not be there still shows up.
        waited = 0;
        while (pending_divides.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_divides.size() != 0)
        begin
            $display("%0t: results never delivered: expected %0d more, actual 0",
                     $time, pending_divides.size());
            mismatches++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("** unsigned_divide_32_by_16_with_flags: PASSED **");
        end
        else
        begin
            $display("** unsigned_divide_32_by_16_with_flags: FAILED **");
        end
        $finish;
    end

    // Watchdog. It ends a run that hangs and reports it as failed.
    initial
    begin
        #400000;
        $display("** unsigned_divide_32_by_16_with_flags: FAILED **");
        $finish;
    end

endmodule

// File: unsigned_divide_32_by_16_with_flags.f
+incdir+rtl/core
rtl/core/udiv_pkg.sv
rtl/core/udiv_cell.sv
rtl/core/udiv_flags.sv
rtl/core/unsigned_divide_32_by_16_with_flags.sv
verif/unsigned_divide_32_by_16_with_flags_tb.sv
